// ===== rtl/sacl_pkg.sv =====
package sacl_pkg;

	localparam int ADDR_W      = 32;
	localparam int WAY_OUT_W   = 2;
	localparam int VTAG_W      = 19;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 1;

	localparam int DEF_NUM_SETS    = 128;
	localparam int DEF_NUM_WAYS    = 4;
	localparam int DEF_OFS_BITS    = 6;
	localparam int DEF_ADDR_BITS   = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_WB_MODE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC = CFG_IDX_W'(1);

	localparam logic FUNC_WRITE = 1'b1;

	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] address;
	} req_item_t;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way_used;
		logic                 allocated;
		logic                 evicted;
		logic                 writeback;
		logic [VTAG_W-1:0]    victim_tag;
		logic                 memory_write;
	} rsp_item_t;

	// write enables produced by the update logic for one access
	typedef struct packed {
		logic state_we;
		logic tag_we;
	} upd_ctrl_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} ctl_state_t;

endpackage

// ===== rtl/sacl_ram.sv =====
module sacl_ram import sacl_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/sacl_update.sv =====
module sacl_update import sacl_pkg::*; #(
	parameter int NUM_WAYS = DEF_NUM_WAYS,
	parameter int TAG_W    = 19,
	parameter int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1,
	parameter int ENTRY_W  = 2 + WAY_W
) (
	input  logic [NUM_WAYS*TAG_W-1:0]   tag_row,
	input  logic [NUM_WAYS*ENTRY_W-1:0] state_row,
	input  logic [TAG_W-1:0]            tag,
	input  logic                        is_write,
	input  logic                        wb_mode,
	input  logic                        write_alloc,
	output upd_ctrl_t                   ctrl,
	output logic [NUM_WAYS*TAG_W-1:0]   tag_row_nxt,
	output logic [NUM_WAYS*ENTRY_W-1:0] state_row_nxt,
	output rsp_item_t                   result
);

	logic [NUM_WAYS-1:0] valid, dirty, match, lru;
	logic [WAY_W-1:0]    rank [NUM_WAYS];
	logic [TAG_W-1:0]    tags [NUM_WAYS];
	logic [NUM_WAYS-1:0] valid_n, dirty_n;
	logic [WAY_W-1:0]    rank_n [NUM_WAYS];
	logic [TAG_W-1:0]    tags_n [NUM_WAYS];
	logic [WAY_W-1:0]    hit_way, free_way, lru_way, way;
	logic                hit, free_any, no_alloc, was_valid, victim_dirty;
	logic [WAY_W-1:0]    way_rank;
	logic [TAG_W-1:0]    vtag;

	always_comb begin
		for (int i = 0; i < NUM_WAYS; i++) begin
			valid[i] = state_row[i*ENTRY_W + ENTRY_W - 1];
			dirty[i] = state_row[i*ENTRY_W + ENTRY_W - 2];
			rank[i]  = state_row[i*ENTRY_W +: WAY_W];
			tags[i]  = tag_row[i*TAG_W +: TAG_W];
			match[i] = valid[i] && (tags[i] == tag);
			lru[i]   = rank[i] == WAY_W'(NUM_WAYS - 1);
		end

		// lowest way wins each search
		hit_way  = '0;
		free_way = '0;
		lru_way  = '0;
		for (int i = NUM_WAYS - 1; i >= 0; i--) begin
			if (match[i]) hit_way = WAY_W'(i);
			if (!valid[i]) free_way = WAY_W'(i);
			if (lru[i]) lru_way = WAY_W'(i);
		end
		hit      = |match;
		free_any = ~&valid;
		no_alloc = !hit && is_write && !write_alloc;
		way      = hit ? hit_way : (free_any ? free_way : lru_way);

		was_valid    = 1'b0;
		way_rank     = '0;
		victim_dirty = 1'b0;
		vtag         = '0;
		for (int i = 0; i < NUM_WAYS; i++) begin
			if (WAY_W'(i) == way) begin
				was_valid = valid[i];
				way_rank  = rank[i];
			end
			if (WAY_W'(i) == lru_way) begin
				victim_dirty = dirty[i];
				vtag         = tags[i];
			end
		end

		// touch: ways more recent than the chosen one age by one, or every valid way when the chosen way was invalid
		for (int i = 0; i < NUM_WAYS; i++) begin
			valid_n[i] = valid[i];
			dirty_n[i] = dirty[i];
			tags_n[i]  = tags[i];
			rank_n[i]  = rank[i];
			if (WAY_W'(i) == way) begin
				rank_n[i] = '0;
				if (!hit) begin
					valid_n[i] = 1'b1;
					dirty_n[i] = is_write;
					tags_n[i]  = tag;
				end else if (is_write && wb_mode) begin
					dirty_n[i] = 1'b1;
				end
			end else if (valid[i] && (!was_valid || rank[i] < way_rank)) begin
				rank_n[i] = rank[i] + WAY_W'(1);
			end
		end

		for (int i = 0; i < NUM_WAYS; i++) begin
			state_row_nxt[i*ENTRY_W +: ENTRY_W] = {valid_n[i], dirty_n[i], rank_n[i]};
			tag_row_nxt[i*TAG_W +: TAG_W]       = tags_n[i];
		end

		ctrl.state_we = !no_alloc;
		ctrl.tag_we   = !hit && !no_alloc;

		result.hit          = hit;
		result.way_used     = no_alloc ? '0 : WAY_OUT_W'(way);
		result.allocated    = !hit && !no_alloc;
		result.evicted      = !hit && !no_alloc && !free_any;
		result.writeback    = !hit && !no_alloc && !free_any && wb_mode && victim_dirty;
		result.victim_tag   = (!hit && !no_alloc && !free_any) ? VTAG_W'(vtag) : '0;
		result.memory_write = is_write && (hit ? !wb_mode : !write_alloc);
	end

endmodule

// ===== rtl/set_assoc_cache_tag_lru.sv =====
// Tag array of a set-associative cache, true LRU, write-back/write-allocate options.
// rsp_valid rises once the accepted item's result is committed in ST_LOOKUP (held while
// rsp_ready is low); no new item is taken before then, set by the read-modify-write of
// the set row (state RAM read in ST_IDLE, update and write-back in ST_LOOKUP).
// Reset: the write-back and write-allocate modes go to 1; then a clearing pass over all
// 2^floor(log2(NUM_SETS)) rows (128 by default) zeroes valid/dirty/LRU, no items taken.
module set_assoc_cache_tag_lru import sacl_pkg::*; #(
	parameter int NUM_SETS      = DEF_NUM_SETS,
	parameter int NUM_WAYS      = DEF_NUM_WAYS,
	parameter int LINE_OFS_BITS = DEF_OFS_BITS,
	parameter int ADDR_BITS     = DEF_ADDR_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_item_t             req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_item_t             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int IDX_W     = $clog2(NUM_SETS + 1) - 1;
	localparam int SET_W     = (IDX_W > 0) ? IDX_W : 1;
	localparam int SETS_USED = 1 << IDX_W;
	localparam int SHIFT     = IDX_W + LINE_OFS_BITS;
	localparam int TAG_W     = (ADDR_BITS > SHIFT) ? ADDR_BITS - SHIFT : 1;
	localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int ENTRY_W   = 2 + WAY_W;

	ctl_state_t state_q, state_d;
	logic [SET_W-1:0] clr_q;
	logic wb_mode_q, write_alloc_q;
	logic commit;

	logic [ADDR_BITS-1:0] addr_full;
	logic [SET_W-1:0]     set_in, set_s1, rd_addr, st_waddr;
	logic [TAG_W-1:0]     tag_in, tag_s1;
	logic                 wr_s1;

	logic [NUM_WAYS*TAG_W-1:0]   tag_rd, tag_nxt;
	logic [NUM_WAYS*ENTRY_W-1:0] st_rd, st_nxt, st_wdata;
	logic                        st_we, tag_we;
	upd_ctrl_t                   ctrl;
	rsp_item_t                   result, rsp_q;
	logic                        rsp_valid_q;

	assign addr_full = ADDR_BITS'(req.address);
	assign set_in    = (IDX_W == 0) ? '0 : SET_W'(addr_full >> LINE_OFS_BITS);
	assign tag_in    = TAG_W'(addr_full >> SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_mode_q     <= 1'b1;
			write_alloc_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WB_MODE:     wb_mode_q     <= cfg_wdata[0];
				CFG_WRITE_ALLOC: write_alloc_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SET_W'(1);
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			set_s1 <= set_in;
			tag_s1 <= tag_in;
			wr_s1  <= req.func == FUNC_WRITE;
		end
		if (commit) begin
			rsp_q <= result;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == SET_W'(SETS_USED - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				// hold the read row until the output register is free
				if (!rsp_valid_q || rsp_ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	assign rd_addr  = (state_q == ST_IDLE) ? set_in : set_s1;
	assign st_we    = (state_q == ST_CLEAR) || (commit && ctrl.state_we);
	assign st_waddr = (state_q == ST_CLEAR) ? clr_q : set_s1;
	assign st_wdata = (state_q == ST_CLEAR) ? '0 : st_nxt;
	assign tag_we   = commit && ctrl.tag_we;

	sacl_ram #(
		.WIDTH(NUM_WAYS * ENTRY_W),
		.DEPTH(SETS_USED)
	) u_state_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(rd_addr),
		.rdata(st_rd)
	);

	sacl_ram #(
		.WIDTH(NUM_WAYS * TAG_W),
		.DEPTH(SETS_USED)
	) u_tag_ram (
		.clk  (clk),
		.we   (tag_we),
		.waddr(set_s1),
		.wdata(tag_nxt),
		.raddr(rd_addr),
		.rdata(tag_rd)
	);

	sacl_update #(
		.NUM_WAYS(NUM_WAYS),
		.TAG_W   (TAG_W)
	) u_update (
		.tag_row      (tag_rd),
		.state_row    (st_rd),
		.tag          (tag_s1),
		.is_write     (wr_s1),
		.wb_mode      (wb_mode_q),
		.write_alloc  (write_alloc_q),
		.ctrl         (ctrl),
		.tag_row_nxt  (tag_nxt),
		.state_row_nxt(st_nxt),
		.result       (result)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid)
		else $error("item result not presented after commit");

	a_accept_looks_up: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == ST_LOOKUP && !req_ready)
		else $error("accepted item not looked up");

	a_tag_with_state: assert property (@(posedge clk) disable iff (!arst_n)
		tag_we |-> st_we && state_q == ST_LOOKUP)
		else $error("tag written without state row update");

	a_hit_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> !rsp.allocated && !rsp.evicted && !rsp.writeback)
		else $error("hit reports a fill");

	a_wb_needs_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.writeback || rsp.evicted) |-> rsp.allocated)
		else $error("eviction without allocation");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import sacl_pkg::*;

	localparam int SETS        = DEF_NUM_SETS;
	localparam int WAYS        = DEF_NUM_WAYS;
	localparam int OFS_W       = DEF_OFS_BITS;
	localparam int SET_W       = $clog2(SETS);
	localparam int TAG_W       = ADDR_W - SET_W - OFS_W;
	localparam int AGE_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 400;

	localparam logic FUNC_READ = ~FUNC_WRITE;
	// indexes past the last register: writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	req_item_t             req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_item_t             rsp;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// shadow copy of the tag array
	logic [TAG_W-1:0] line_tag   [SETS*WAYS];
	bit               line_valid [SETS*WAYS];
	bit               line_dirty [SETS*WAYS];
	bit [AGE_W-1:0]   line_age   [SETS*WAYS];
	bit               wb_mode;
	bit               alloc_mode;

	req_item_t pending_req [$];
	rsp_item_t lookup_rsp  [$];
	int        outstanding = 0;
	int        err_count = 0;
	bit        req_taken = 1'b0;
	longint    cycle_count = 0;
	int        gap_left = 0;
	int        burst_left = 8;
	int        stall_mode = 0;

	set_assoc_cache_tag_lru dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// move way w to most recently used; only ways newer than it age,
	// or every valid way when w is being filled
	function automatic void refresh_lru(int base, int w);
		bit             was_valid;
		bit [AGE_W-1:0] r;
		was_valid = line_valid[base + w];
		r = line_age[base + w];
		for (int i = 0; i < WAYS; i++)
			if (i != w && line_valid[base + i] && (!was_valid || line_age[base + i] < r))
				line_age[base + i]++;
		line_age[base + w] = '0;
	endfunction

	function automatic rsp_item_t predict_access(req_item_t it);
		rsp_item_t        o;
		logic [SET_W-1:0] set_idx;
		logic [TAG_W-1:0] tag;
		int               base;
		int               way;
		bit               found;
		bit               have_free;
		bit               is_wr;
		o = '0;
		set_idx = it.address[OFS_W +: SET_W];
		tag = it.address[ADDR_W-1 -: TAG_W];
		base = set_idx * WAYS;
		is_wr = (it.func == FUNC_WRITE);
		found = 1'b0;
		have_free = 1'b0;
		way = 0;
		for (int i = 0; i < WAYS; i++)
			if (!found && line_valid[base + i] && line_tag[base + i] == tag) begin
				found = 1'b1;
				way = i;
			end
		if (found) begin
			o.hit = 1'b1;
			refresh_lru(base, way);
			if (is_wr) begin
				if (wb_mode)
					line_dirty[base + way] = 1'b1;
				else
					o.memory_write = 1'b1;
			end
		end else if (is_wr && !alloc_mode) begin
			o.memory_write = 1'b1;
			way = 0;
		end else begin
			for (int i = 0; i < WAYS; i++)
				if (!have_free && !line_valid[base + i]) begin
					have_free = 1'b1;
					way = i;
				end
			if (!have_free) begin
				way = 0;
				for (int i = 1; i < WAYS; i++)
					if (line_age[base + i] > line_age[base + way])
						way = i;
				o.evicted = 1'b1;
				o.victim_tag = VTAG_W'(line_tag[base + way]);
				o.writeback = wb_mode && line_dirty[base + way];
			end
			refresh_lru(base, way);
			line_tag[base + way] = tag;
			line_valid[base + way] = 1'b1;
			line_dirty[base + way] = is_wr;
			o.allocated = 1'b1;
		end
		o.way_used = WAY_OUT_W'(way);
		return o;
	endfunction

	function automatic logic [ADDR_W-1:0] mk_addr(logic [TAG_W-1:0] tag,
			logic [SET_W-1:0] set_idx, logic [OFS_W-1:0] ofs);
		return {tag, set_idx, ofs};
	endfunction

	function automatic void queue_access(logic f, logic [ADDR_W-1:0] addr);
		req_item_t it;
		it.func = f;
		it.address = addr;
		pending_req.push_back(it);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, bit val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		unique case (idx)
			CFG_WB_MODE:     wb_mode = val;
			CFG_WRITE_ALLOC: alloc_mode = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every issued item has produced its result, plus an idle margin
	task automatic drain();
		while (pending_req.size() != 0 || outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// driver: bursts of items with random gaps; receiver stall pattern
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pending_req.size() > 0) begin
				req <= pending_req.pop_front();
				req_valid <= 1'b1;
				outstanding++;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
		if (cycle_count % 97 == 0)
			stall_mode = $urandom_range(0, 3);
		unique case (stall_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= 1'($urandom_range(0, 1));
			2: rsp_ready <= (cycle_count % 4 == 0);
			default: rsp_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// monitor: predict on each accepted item, check each accepted result
	always @(posedge clk) begin
		rsp_item_t want;
		if (rsp_valid && rsp_ready) begin
			if (outstanding > 0)
				outstanding--;
			if (lookup_rsp.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result: expected none, got %h", $time, rsp);
			end else begin
				want = lookup_rsp.pop_front();
				check_field("hit", 32'(want.hit), 32'(rsp.hit));
				check_field("way_used", 32'(want.way_used), 32'(rsp.way_used));
				check_field("allocated", 32'(want.allocated), 32'(rsp.allocated));
				check_field("evicted", 32'(want.evicted), 32'(rsp.evicted));
				check_field("writeback", 32'(want.writeback), 32'(rsp.writeback));
				check_field("victim_tag", 32'(want.victim_tag), 32'(rsp.victim_tag));
				check_field("memory_write", 32'(want.memory_write),
					32'(rsp.memory_write));
			end
		end
		req_taken = req_valid && req_ready;
		if (req_taken)
			lookup_rsp.push_back(predict_access(req));
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [TAG_W-1:0]  tag_pool [6];
		logic [SET_W-1:0]  set_pool [4];
		logic [ADDR_W-1:0] addr;
		bit                wb_seq [5] = '{1, 0, 1, 0, 1};
		bit                wa_seq [5] = '{1, 1, 0, 0, 1};
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		wb_mode = 1'b1;
		alloc_mode = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// the block clears its state after reset before taking items
		while (!req_ready)
			@(negedge clk);

		write_cfg(CFG_WB_MODE, 1'b1);
		write_cfg(CFG_WRITE_ALLOC, 1'b1);
		// fill all four ways of set 5, hit, then evict a dirty line
		queue_access(FUNC_READ,  mk_addr(TAG_W'('h00001), SET_W'(5), OFS_W'(0)));
		queue_access(FUNC_READ,  mk_addr(TAG_W'('h00001), SET_W'(5), OFS_W'(63)));
		queue_access(FUNC_WRITE, mk_addr(TAG_W'('h7ffff), SET_W'(5), OFS_W'(1)));
		queue_access(FUNC_READ,  mk_addr(TAG_W'('h2aaaa), SET_W'(5), OFS_W'(2)));
		queue_access(FUNC_READ,  mk_addr(TAG_W'('h55555), SET_W'(5), OFS_W'(3)));
		queue_access(FUNC_WRITE, mk_addr(TAG_W'('h00001), SET_W'(5), OFS_W'(4)));
		queue_access(FUNC_READ,  mk_addr(TAG_W'('h00000), SET_W'(5), OFS_W'(5)));
		queue_access(FUNC_READ,  mk_addr(TAG_W'('h2aaaa), SET_W'(5), OFS_W'(6)));
		queue_access(FUNC_READ,  '0);
		queue_access(FUNC_WRITE, '1);
		queue_access(FUNC_READ,  '1);
		drain();

		// write-through, no-allocate; writes to unused indexes must not stick
		write_cfg(CFG_WB_MODE, 1'b0);
		write_cfg(CFG_WRITE_ALLOC, 1'b0);
		write_cfg(CFG_SPARE_LO, 1'b1);
		write_cfg(CFG_SPARE_HI, 1'b1);
		queue_access(FUNC_WRITE, mk_addr(TAG_W'('h00001), SET_W'(5), OFS_W'(7)));
		queue_access(FUNC_WRITE, mk_addr(TAG_W'('h7ffff), SET_W'(5), OFS_W'(8)));
		queue_access(FUNC_READ,  mk_addr(TAG_W'('h7ffff), SET_W'(5), OFS_W'(9)));
		queue_access(FUNC_READ,  mk_addr(TAG_W'('h12345), SET_W'(5), OFS_W'(10)));
		queue_access(FUNC_READ,  mk_addr(TAG_W'('h23456), SET_W'(5), OFS_W'(11)));
		queue_access(FUNC_READ,  mk_addr(TAG_W'('h34567), SET_W'(5), OFS_W'(12)));

		for (int p = 0; p < 5; p++) begin
			drain();
			write_cfg(CFG_WB_MODE, wb_seq[p]);
			write_cfg(CFG_WRITE_ALLOC, wa_seq[p]);
			foreach (tag_pool[k])
				tag_pool[k] = TAG_W'($urandom);
			foreach (set_pool[k])
				set_pool[k] = SET_W'($urandom);
			// mostly a few hot tags in a few sets so hits and evictions are frequent
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 85)
					addr = mk_addr(tag_pool[$urandom_range(0, 5)],
						set_pool[$urandom_range(0, 3)], OFS_W'($urandom));
				else
					addr = $urandom;
				queue_access($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, addr);
			end
		end
		drain();

		if (err_count == 0 && lookup_rsp.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
